// File: sv/slss_pkg.sv
// types and constants shared by the sorted list store blocks
// depends on nothing
package slss_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned PosW  = 6;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_SORT   = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // compare unit flags
  typedef struct packed {
    logic gt;
    logic eq;
  } cmp_t;

  // result word handed from the sequencer to the output register
  typedef struct packed {
    logic              valid;
    status_e           status;
    logic [PosW-1:0]   pos;
  } res_t;

endpackage

// File: sv/sorted_list_store_with_search.sv
// channel  | signals                                   | word
// ---------+-------------------------------------------+-------------------------
// input    | in_valid_i, in_ready_o, cmd_i, value_i    | one command and operand
// output   | out_valid_o, out_ready_i, status_o,       | one result per command
//          | position_o                                |
//
// clear and append answer straight from idle; search to the k-th entry walks the entries in order
// (one ram read then one compare per entry); sort of n entries runs exchange passes,
// one compare per cycle within a pass through the single ram read port.
// the output register frees the sequencer; a waiting result holds the next command.
// reset clears the entry count; stored values stay undefined until written.
// depends on slss_pkg, slss_ctrl, slss_ram, slss_cmp
module sorted_list_store_with_search #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          cmd_i,
  input  logic signed [slss_pkg::DataW-1:0]   value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          status_o,
  output logic [slss_pkg::PosW-1:0]           position_o
);

  localparam int unsigned AW = $clog2(CAPACITY);

  slss_pkg::res_t                    res;
  slss_pkg::cmp_t                    cmp;
  logic                              res_ready;
  logic                              we;
  logic [AW-1:0]                     waddr;
  logic [AW-1:0]                     raddr;
  logic signed [slss_pkg::DataW-1:0] wdata;
  logic signed [slss_pkg::DataW-1:0] rdata;
  logic signed [slss_pkg::DataW-1:0] cmp_a;
  logic                              ov_q;
  slss_pkg::status_e                 status_q;
  logic [slss_pkg::PosW-1:0]         pos_q;

  assign res_ready = !ov_q || out_ready_i;

  slss_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (slss_pkg::cmd_e'(cmd_i)),
    .value_i     (value_i),
    .res_ready_i (res_ready),
    .res_o       (res),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .cmp_a_o     (cmp_a),
    .cmp_i       (cmp)
  );

  slss_ram #(
    .WIDTH (slss_pkg::DataW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  slss_cmp u_cmp (
    .a_i   (cmp_a),
    .b_i   (rdata),
    .cmp_o (cmp)
  );

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (res.valid && res_ready) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      status_q <= res.status;
      pos_q    <= res.pos;
    end
  end

  assign out_valid_o = ov_q;
  assign status_o    = status_q;
  assign position_o  = pos_q;

endmodule

// File: sv/slss_ram.sv
// generic single-write, single-read ram with registered read data
// depends on nothing
module slss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/slss_cmp.sv
// shared compare unit: signed greater-than and equality of two words
// depends on slss_pkg
module slss_cmp (
  input  logic signed [slss_pkg::DataW-1:0] a_i,
  input  logic signed [slss_pkg::DataW-1:0] b_i,
  output slss_pkg::cmp_t                    cmp_o
);

  assign cmp_o.gt = (a_i > b_i);
  assign cmp_o.eq = (a_i == b_i);

endmodule

// File: sv/slss_ctrl.sv
// sequencer for clear, append, exchange sort and linear search
// depends on slss_pkg; drives the element ram and the shared compare unit
module slss_ctrl #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  slss_pkg::cmd_e                    cmd_i,
  input  logic signed [slss_pkg::DataW-1:0] value_i,
  input  logic                              res_ready_i,
  output slss_pkg::res_t                    res_o,
  output logic                              we_o,
  output logic [$clog2(CAPACITY)-1:0]       waddr_o,
  output logic signed [slss_pkg::DataW-1:0] wdata_o,
  output logic [$clog2(CAPACITY)-1:0]       raddr_o,
  input  logic signed [slss_pkg::DataW-1:0] rdata_i,
  output logic signed [slss_pkg::DataW-1:0] cmp_a_o,
  input  slss_pkg::cmp_t                    cmp_i
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_RD_I   = 8'b0000_0010,
    S_LD_I   = 8'b0000_0100,
    S_CMP    = 8'b0000_1000,
    S_WR_I   = 8'b0001_0000,
    S_SR_RD  = 8'b0010_0000,
    S_SR_CMP = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  state_e                            state_q, state_d;
  logic [CW-1:0]                     count_q, count_d;
  logic [CW-1:0]                     i_q, i_d;
  logic [CW-1:0]                     j_q, j_d;
  logic [CW-1:0]                     j_inc;
  logic signed [slss_pkg::DataW-1:0] cur_q, cur_d;
  slss_pkg::status_e                 rs_q, rs_d;
  logic [slss_pkg::PosW-1:0]         rp_q, rp_d;
  logic                              accept;

  assign in_ready_o = (state_q == S_IDLE) && res_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign j_inc      = j_q + CW'(1);
  assign cmp_a_o    = cur_q;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    i_d        = i_q;
    j_d        = j_q;
    cur_d      = cur_q;
    rs_d       = rs_q;
    rp_d       = rp_q;
    we_o       = 1'b0;
    waddr_o    = count_q[AW-1:0];
    wdata_o    = value_i;
    raddr_o    = i_q[AW-1:0];
    res_o.valid  = 1'b0;
    res_o.status = rs_q;
    res_o.pos    = rp_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_o.pos = '0;
          unique case (cmd_i)
            slss_pkg::CMD_CLEAR: begin
              count_d      = '0;
              res_o.valid  = 1'b1;
              res_o.status = slss_pkg::ST_DONE;
            end
            slss_pkg::CMD_APPEND: begin
              res_o.valid = 1'b1;
              if (count_q == CW'(CAPACITY)) begin
                res_o.status = slss_pkg::ST_FULL;
              end else begin
                we_o         = 1'b1;
                count_d      = count_q + CW'(1);
                res_o.status = slss_pkg::ST_DONE;
              end
            end
            slss_pkg::CMD_SORT: begin
              if (count_q < CW'(2)) begin
                res_o.valid  = 1'b1;
                res_o.status = slss_pkg::ST_DONE;
              end else begin
                i_d     = '0;
                state_d = S_RD_I;
              end
            end
            slss_pkg::CMD_SEARCH: begin
              if (count_q == '0) begin
                res_o.valid  = 1'b1;
                res_o.status = slss_pkg::ST_NOT_FOUND;
              end else begin
                cur_d   = value_i;
                j_d     = '0;
                state_d = S_SR_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD_I: begin
        raddr_o = i_q[AW-1:0];
        j_d     = i_q + CW'(1);
        state_d = S_LD_I;
      end
      S_LD_I: begin
        cur_d   = rdata_i;
        raddr_o = j_q[AW-1:0];
        state_d = S_CMP;
      end
      S_CMP: begin
        // entry i lives in cur_q until its pass ends; swap into slot j
        if (cmp_i.gt) begin
          we_o    = 1'b1;
          waddr_o = j_q[AW-1:0];
          wdata_o = cur_q;
          cur_d   = rdata_i;
        end
        if (j_inc == count_q) begin
          state_d = S_WR_I;
        end else begin
          j_d     = j_inc;
          raddr_o = j_inc[AW-1:0];
        end
      end
      S_WR_I: begin
        we_o    = 1'b1;
        waddr_o = i_q[AW-1:0];
        wdata_o = cur_q;
        if (i_q + CW'(2) == count_q) begin
          rs_d    = slss_pkg::ST_DONE;
          rp_d    = '0;
          state_d = S_DONE;
        end else begin
          i_d     = i_q + CW'(1);
          state_d = S_RD_I;
        end
      end
      S_SR_RD: begin
        raddr_o = j_q[AW-1:0];
        state_d = S_SR_CMP;
      end
      S_SR_CMP: begin
        if (cmp_i.eq) begin
          rs_d    = slss_pkg::ST_FOUND;
          rp_d    = slss_pkg::PosW'(j_q);
          state_d = S_DONE;
        end else if (j_inc == count_q) begin
          rs_d    = slss_pkg::ST_NOT_FOUND;
          rp_d    = '0;
          state_d = S_DONE;
        end else begin
          j_d     = j_inc;
          state_d = S_SR_RD;
        end
      end
      S_DONE: begin
        res_o.valid = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    rs_q  <= rs_d;
    rp_q  <= rp_d;
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_sort_indices: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> ((i_q < j_q) && (j_q < count_q)))
    else $error("sort compare with bad indices");

  a_wr_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR_I) |=> ((state_q == S_RD_I) || (state_q == S_DONE)))
    else $error("sort pass did not continue or finish");

  a_count_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |=> (count_q == $past(count_q)))
    else $error("entry count changed during sort or search");

endmodule

// File: test/slss_checker.sv
// checker for the sorted list store: tracks the list beside the block, predicts
// one result per accepted command word and compares each result word in order
// depends on slss_pkg
module slss_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic [1:0]                         cmd_i,
  input  logic signed [slss_pkg::DataW-1:0]  value_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic [1:0]                         status_i,
  input  logic [slss_pkg::PosW-1:0]          position_i,
  output int                                 errors_o,
  output int                                 pending_o
);
  import slss_pkg::*;

  typedef struct {
    status_e               status;
    logic [PosW-1:0]       pos;
  } outcome_t;

  logic signed [DataW-1:0] list_vals [CAPACITY];
  int unsigned             list_len;
  outcome_t                outcome_q [$];
  int                      err_cnt;

  // exchange sort: entry i against every later entry, swap only on strictly greater
  function automatic void sort_list();
    logic signed [DataW-1:0] tmp;
    for (int i = 0; i + 1 < int'(list_len); i++) begin
      for (int j = i + 1; j < int'(list_len); j++) begin
        if (list_vals[i] > list_vals[j]) begin
          tmp          = list_vals[i];
          list_vals[i] = list_vals[j];
          list_vals[j] = tmp;
        end
      end
    end
  endfunction

  function automatic outcome_t apply_command(cmd_e c, logic signed [DataW-1:0] v);
    outcome_t res;
    res.status = ST_DONE;
    res.pos    = '0;
    case (c)
      CMD_CLEAR: begin
        list_len = 0;
      end
      CMD_APPEND: begin
        if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          list_vals[list_len] = v;
          list_len++;
        end
      end
      CMD_SORT: begin
        sort_list();
      end
      default: begin
        res.status = ST_NOT_FOUND;
        for (int i = 0; i < int'(list_len); i++) begin
          if (list_vals[i] == v) begin
            res.status = ST_FOUND;
            res.pos    = PosW'(i);
            break;
          end
        end
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    outcome_t want;
    if (!rst_ni) begin
      list_len = 0;
      err_cnt  = 0;
      outcome_q.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: result word with nothing expected: status %0d position %0d",
                   $time, status_i, position_i);
          err_cnt++;
        end else begin
          want = outcome_q.pop_front();
          if (status_i !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_i);
            err_cnt++;
          end
          if (position_i !== want.pos) begin
            $display("%0t: position expected %0d actual %0d", $time, want.pos, position_i);
            err_cnt++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        outcome_q.push_back(apply_command(cmd_e'(cmd_i), value_i));
      end
      errors_o  <= err_cnt;
      pending_o <= outcome_q.size();
    end
  end

endmodule

// File: test/tb.sv
// testbench top for sorted_list_store_with_search: clock, reset, command words
// and output stalls; prediction and checking live in slss_checker
// depends on slss_pkg, slss_checker and the block
module tb;
  import slss_pkg::*;

  localparam int unsigned CAPACITY = 64;
  localparam int          N_RANDOM = 1550;
  localparam longint      SORT_CYC = (CAPACITY - 1) * (CAPACITY + 6) / 2 + 2;
  localparam longint      LIMIT    = 4 * (N_RANDOM + 100) * (SORT_CYC + 2 * CAPACITY + 200);

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  cmd_e                    word_cmd    = CMD_CLEAR;
  logic signed [DataW-1:0] word_value  = '0;
  logic                    out_ready_i = 1'b0;
  logic                    in_ready_o;
  logic                    out_valid_o;
  logic [1:0]              status_o;
  logic [PosW-1:0]         position_o;
  int                      mismatches;
  int                      pending;

  int                      sent    = 0;
  bit                      tx_calm = 1'b0;
  bit                      rx_calm = 1'b0;
  int                      rx_hold = 0;
  longint                  cycle_cnt;
  logic signed [DataW-1:0] shadow_vals [$];

  sorted_list_store_with_search #(.CAPACITY(CAPACITY)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (word_cmd),
    .value_i     (word_value),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .position_o  (position_o)
  );

  slss_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .cmd_i       (word_cmd),
    .value_i     (word_value),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status_o),
    .position_i  (position_o),
    .errors_o    (mismatches),
    .pending_o   (pending)
  );

  always #10 clk_i = ~clk_i;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // small values give duplicates, a few extremes, the rest full range
  function automatic logic signed [DataW-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $signed($urandom_range(0, 6)) - 3;
    if (r == 4) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7fff_ffff;
        2:       return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return $urandom();
  endfunction

  function automatic logic signed [DataW-1:0] pick_target();
    if (shadow_vals.size() > 0 && $urandom_range(0, 4) < 3)
      return shadow_vals[$urandom_range(0, shadow_vals.size() - 1)];
    return pick_value();
  endfunction

  // output side stalls, with calm stretches of steady ready
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      out_ready_i <= 1'b0;
      rx_hold     <= rx_hold - 1;
    end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
      out_ready_i <= 1'b0;
      rx_hold     <= pick_gap();
    end else begin
      out_ready_i <= 1'b1;
    end
    if ($urandom_range(0, 299) == 0) rx_calm <= !rx_calm;
  end

  task automatic send(input cmd_e c, input logic signed [DataW-1:0] v);
    int gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    word_cmd   <= c;
    word_value <= v;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
    if (c == CMD_CLEAR) shadow_vals.delete();
    if (c == CMD_APPEND && shadow_vals.size() < CAPACITY) shadow_vals.push_back(v);
    if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
  endtask

  // hold the sender until every result word is back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic run_sequence(input bit fill_up);
    int r;
    int n_app;
    r = $urandom_range(0, 99);
    if (fill_up) n_app = CAPACITY + 3;
    else if (r < 70) n_app = $urandom_range(0, 8);
    else if (r < 92) n_app = $urandom_range(9, 30);
    else n_app = $urandom_range(CAPACITY - 4, CAPACITY + 6);
    if ($urandom_range(0, 9) != 0) send(CMD_CLEAR, pick_value());
    repeat (n_app) begin
      send(CMD_APPEND, pick_value());
      if ($urandom_range(0, 7) == 0) send(CMD_SEARCH, pick_target());
    end
    if ($urandom_range(0, 9) < 8) send(CMD_SORT, pick_value());
    repeat ($urandom_range(1, 6)) send(CMD_SEARCH, pick_target());
    // broken sequence: arbitrary commands
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 5)) send(cmd_e'($urandom_range(0, 3)), pick_value());
    end
  endtask

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int stop_at;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list: search misses, sort does nothing
    send(CMD_SEARCH, 32'sd0);
    send(CMD_SORT, 32'sh7fff_ffff);
    send(CMD_APPEND, 32'sh7fff_ffff);
    send(CMD_SORT, 32'sd0);
    send(CMD_APPEND, 32'sh8000_0000);
    send(CMD_APPEND, 32'sd0);
    send(CMD_APPEND, -32'sd1);
    send(CMD_APPEND, 32'sd1);
    send(CMD_APPEND, 32'sh7fff_ffff);
    send(CMD_APPEND, 32'sh8000_0000);
    send(CMD_SEARCH, 32'sh8000_0000);
    send(CMD_SEARCH, 32'sd12345);
    // equal entries stay in place, first match reported
    send(CMD_SORT, -32'sd1);
    send(CMD_SEARCH, 32'sh7fff_ffff);
    send(CMD_SEARCH, 32'sh8000_0000);
    send(CMD_SEARCH, -32'sd1);
    // stale words after clear must not be found
    send(CMD_CLEAR, 32'sh5555_aaaa);
    send(CMD_SEARCH, -32'sd1);
    send(CMD_SEARCH, 32'sh7fff_ffff);
    send(CMD_APPEND, 32'sd5);
    send(CMD_SEARCH, 32'sd5);
    drain();

    stop_at = sent + N_RANDOM;
    run_sequence(1'b1);
    while (sent < stop_at) begin
      run_sequence(1'b0);
      if ($urandom_range(0, 9) == 0) drain();
    end

    drain();
    repeat (4 * CAPACITY + 20) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
